// ===== rtl/fnas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnas_pkg
// Shared types and constants of the four-neighbor average smoother.
// ----------------------------------------------------------------------------
package fnas_pkg;

  // default sizing of the line memory and the pixel path
  localparam int DEF_MAX_ROW_LENGTH = 2048;
  localparam int DEF_PIXEL_BITS     = 31;

  // configuration register widths and limits
  localparam int ROW_LENGTH_BITS = 12;
  localparam int ROW_COUNT_BITS  = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int ROW_POS_BITS    = 12;
  localparam int MAX_ROWS        = 4096;
  localparam int MIN_DIM         = 3;

  // register values after reset
  localparam int DEF_ROW_LENGTH = 1080;
  localparam int DEF_ROW_COUNT  = 1920;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT  = 1'b1;

  // line memory read sequencer
  typedef enum logic [1:0] {
    ST_PRIME_CUR,
    ST_PRIME_NEXT,
    ST_RUN
  } fnas_state_t;

  // which results one accepted pixel produces
  typedef struct packed {
    logic first_valid;   // smoothed pixel of the row above
    logic second_valid;  // final row pass-through pixel
    logic frame_end;     // pass-through pixel closes the frame
  } fnas_flags_t;

endpackage

// ===== rtl/fnas_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnas_outq
// Two-entry result queue. Each entry holds the one or two results caused by
// one input pixel and hands them out one per transfer.
// ----------------------------------------------------------------------------
module fnas_outq
  import fnas_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_en,
  input  logic [PIXEL_BITS-1:0] push_smooth,
  input  logic [PIXEL_BITS-1:0] push_pass,
  input  fnas_flags_t           push_flags,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] out_pixel_out,
  output logic                  out_end_of_run,
  output logic                  out_end_of_frame
);

  localparam int DEPTH = 2;

  logic [PIXEL_BITS-1:0] smooth_q [DEPTH];
  logic [PIXEL_BITS-1:0] pass_q   [DEPTH];
  fnas_flags_t           flags_q  [DEPTH];

  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       phase_r, phase_nxt;

  fnas_flags_t head;
  logic        show_first;
  logic        xfer;
  logic        pop;

  // head entry and which of its results is on the port
  assign head       = flags_q[rd_ptr_r];
  assign show_first = head.first_valid && !phase_r;
  assign full       = (count_r == 2'(DEPTH));
  assign out_valid  = (count_r != 2'd0);

  always_comb begin
    if (show_first) begin
      out_pixel_out    = smooth_q[rd_ptr_r];
      out_end_of_run   = !head.second_valid;
      out_end_of_frame = 1'b0;
    end else begin
      out_pixel_out    = pass_q[rd_ptr_r];
      out_end_of_run   = 1'b1;
      out_end_of_frame = head.frame_end;
    end
  end

  // entry leaves after its last result
  assign xfer = out_valid && !out_stall;
  assign pop  = xfer && (!show_first || !head.second_valid);

  always_comb begin
    wr_ptr_nxt = push_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_en} - {1'b0, pop};
    phase_nxt  = phase_r;
    if (pop) begin
      phase_nxt = 1'b0;
    end else if (xfer) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      phase_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_en) begin
      smooth_q[wr_ptr_r] <= push_smooth;
      pass_q[wr_ptr_r]   <= push_pass;
      flags_q[wr_ptr_r]  <= push_flags;
    end
  end

endmodule

// ===== rtl/four_neighbour_average_smoother_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_neighbour_average_smoother_unit
// One smoothing pass over a raster-order frame: each interior pixel becomes
// the floor of the mean of its four neighbors, border pixels pass through.
// ----------------------------------------------------------------------------
// Pixels enter one per clock while the input is not stalled, and each
// transfer's results are registered in the result queue. Output row r comes
// out while input row r+1 goes in; the first input row gives no result and
// each pixel of the final row gives two (the smoothed pixel above, then the
// pixel itself), so during the final row the single output port holds the
// input back. The previous and the current row live in one line memory of
// MAX_ROW_LENGTH words, read one column ahead through a registered port.
// After reset and after every configuration write the input is stalled
// while that read-ahead is primed at the current column.
module four_neighbour_average_smoother_unit
  import fnas_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
  parameter int PIXEL_BITS     = DEF_PIXEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input pixel channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [PIXEL_BITS-1:0]     in_pixel_in,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PIXEL_BITS-1:0]     out_pixel_out,
  output logic                      out_end_of_run,
  output logic                      out_end_of_frame,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int COL_W    = $clog2(MAX_ROW_LENGTH);
  localparam int WORD_W   = 2 * PIXEL_BITS;
  localparam int SUM_W    = PIXEL_BITS + 2;
  localparam int RST_LAST_COL =
    (DEF_ROW_LENGTH > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH - 1 : DEF_ROW_LENGTH - 1;
  localparam int RST_LAST_ROW = DEF_ROW_COUNT - 1;

  // line memory word: {upper row pixel, center row pixel}
  logic [WORD_W-1:0] line_mem [MAX_ROW_LENGTH];
  logic [WORD_W-1:0] line_rd_r;
  logic [WORD_W-1:0] cur_r;

  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_POS_BITS-1:0] row_r, row_nxt;
  logic [COL_W-1:0]        last_col_r, last_col_nxt;
  logic [ROW_POS_BITS-1:0] last_row_r, last_row_nxt;
  logic [PIXEL_BITS-1:0]   left_r;
  fnas_state_t             state_r, state_nxt;

  logic                    cfg_wr;
  logic                    accept;
  logic                    in_open;
  logic                    rd_en;
  logic                    cur_load;
  logic [COL_W-1:0]        rd_addr;
  logic [COL_W-1:0]        next1;
  logic [COL_W-1:0]        next2;
  logic                    last_col;
  logic                    final_row;
  logic                    interior;
  logic [PIXEL_BITS-1:0]   mid;
  logic [PIXEL_BITS-1:0]   upper;
  logic [PIXEL_BITS-1:0]   right;
  logic [SUM_W-1:0]        sum;
  logic [PIXEL_BITS-1:0]   smooth;
  logic                    q_full;
  logic                    push_en;
  fnas_flags_t             push_flags;
  logic [ROW_LENGTH_BITS-1:0] cfg_len;
  logic [ROW_COUNT_BITS-1:0]  cfg_rows;

  // configuration port never back-pressures
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // clamp written values to the supported frame size, keep last index
  assign cfg_len  = cfg_data[ROW_LENGTH_BITS-1:0];
  assign cfg_rows = cfg_data[ROW_COUNT_BITS-1:0];

  always_comb begin
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    if (cfg_wr && cfg_index == CFG_ROW_LENGTH) begin
      if (32'(cfg_len) < 32'(MIN_DIM)) begin
        last_col_nxt = COL_W'(MIN_DIM - 1);
      end else if (32'(cfg_len) > 32'(MAX_ROW_LENGTH)) begin
        last_col_nxt = COL_W'(MAX_ROW_LENGTH - 1);
      end else begin
        last_col_nxt = COL_W'(cfg_len - ROW_LENGTH_BITS'(1));
      end
    end
    if (cfg_wr && cfg_index == CFG_ROW_COUNT) begin
      if (32'(cfg_rows) < 32'(MIN_DIM)) begin
        last_row_nxt = ROW_POS_BITS'(MIN_DIM - 1);
      end else if (32'(cfg_rows) > 32'(MAX_ROWS)) begin
        last_row_nxt = ROW_POS_BITS'(MAX_ROWS - 1);
      end else begin
        last_row_nxt = ROW_POS_BITS'(cfg_rows - ROW_COUNT_BITS'(1));
      end
    end
  end

  // column order: the one after the current, and the one after that
  assign last_col  = (col_r >= last_col_r);
  assign final_row = (row_r >= last_row_r);
  assign next1     = last_col ? '0 : col_r + COL_W'(1);
  assign next2     = (next1 >= last_col_r) ? '0 : next1 + COL_W'(1);

  // read-ahead sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_PRIME_CUR:  state_nxt = ST_PRIME_NEXT;
      ST_PRIME_NEXT: state_nxt = ST_RUN;
      ST_RUN:        state_nxt = ST_RUN;
      default:       state_nxt = ST_PRIME_CUR;
    endcase
    if (cfg_wr) begin
      state_nxt = ST_PRIME_CUR;
    end
  end

  // read-ahead sequencer: outputs
  always_comb begin
    in_open  = 1'b0;
    rd_en    = 1'b0;
    cur_load = 1'b0;
    rd_addr  = col_r;
    case (state_r)
      ST_PRIME_CUR: begin
        rd_en   = 1'b1;
        rd_addr = col_r;
      end
      ST_PRIME_NEXT: begin
        rd_en    = 1'b1;
        cur_load = 1'b1;
        rd_addr  = next1;
      end
      ST_RUN: begin
        in_open  = 1'b1;
        rd_en    = accept;
        cur_load = accept;
        rd_addr  = next2;
      end
      default: begin
        in_open = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full || !in_open;
  assign accept   = in_valid && !in_stall;

  // neighbors of the output pixel at the current column
  assign mid      = cur_r[PIXEL_BITS-1:0];
  assign upper    = cur_r[WORD_W-1:PIXEL_BITS];
  assign right    = line_rd_r[PIXEL_BITS-1:0];
  assign interior = (row_r >= ROW_POS_BITS'(2)) && (row_r <= last_row_r)
                    && (col_r != '0) && !last_col;
  assign sum      = SUM_W'(upper) + SUM_W'(in_pixel_in) + SUM_W'(left_r)
                    + SUM_W'(right);
  assign smooth   = interior ? sum[SUM_W-1:2] : mid;

  // results caused by this pixel
  assign push_flags.first_valid  = (row_r != '0);
  assign push_flags.second_valid = final_row;
  assign push_flags.frame_end    = final_row && last_col;
  assign push_en = accept && (push_flags.first_valid || push_flags.second_valid);

  // raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = final_row ? '0 : row_r + ROW_POS_BITS'(1);
      end else begin
        col_nxt = next1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_PRIME_CUR;
      col_r      <= '0;
      row_r      <= '0;
      last_col_r <= COL_W'(RST_LAST_COL);
      last_row_r <= ROW_POS_BITS'(RST_LAST_ROW);
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
    end
  end

  // line memory: shift the column down one row, read two columns ahead
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_r] <= {mid, in_pixel_in};
    end
    if (rd_en) begin
      line_rd_r <= line_mem[rd_addr];
    end
  end

  // current column word and left neighbor
  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur_r <= line_rd_r;
    end
    if (accept) begin
      left_r <= mid;
    end
  end

  fnas_outq #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .push_en          (push_en),
    .push_smooth      (smooth),
    .push_pass        (in_pixel_in),
    .push_flags       (push_flags),
    .full             (q_full),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// ===== sim/fnas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnas_checker
// Watches the pixel, result and register channels of the smoother, keeps its
// own copy of the line stores and frame position, predicts every result of
// each pixel transfer and compares the result stream against it in order.
// ----------------------------------------------------------------------------
module fnas_checker
  import fnas_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
  parameter int PIXEL_BITS     = DEF_PIXEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [PIXEL_BITS-1:0]     in_pixel_in,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [PIXEL_BITS-1:0]     out_pixel_out,
  input  logic                      out_end_of_run,
  input  logic                      out_end_of_frame,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        fail_count,
  output int                        pending,
  output int                        frame_rest,
  output int                        results_seen
);

  localparam int COL_BITS = $clog2(MAX_ROW_LENGTH);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  run_end;
    logic                  frame_end;
  } smoothed_t;

  smoothed_t                   expected_pixels[$];
  logic [PIXEL_BITS-1:0]       upper_row [MAX_ROW_LENGTH];
  logic [PIXEL_BITS-1:0]       centre_row[MAX_ROW_LENGTH];
  logic [ROW_POS_BITS-1:0]     row_pos;
  logic [COL_BITS-1:0]         col_pos;
  logic [ROW_LENGTH_BITS-1:0]  row_length;
  logic [ROW_COUNT_BITS-1:0]   row_count;
  int                          errors = 0;
  int                          seen = 0;

  // line stores start at zero; only the first row of the first frame copies them
  initial begin
    for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
      upper_row[i]  = '0;
      centre_row[i] = '0;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // pixels still to come before the frame position returns to the top left
  function automatic int rest_of_frame();
    int unsigned w;
    int unsigned h;
    int unsigned row_left;
    w = clamp_dim(int'(row_length), MAX_ROW_LENGTH);
    h = clamp_dim(int'(row_count), MAX_ROWS);
    row_left = (int'(col_pos) >= w - 1) ? 1 : w - int'(col_pos);
    if (int'(row_pos) >= h - 1) return row_left;
    return row_left + (h - 1 - int'(row_pos)) * w;
  endfunction

  // results caused by one pixel transfer
  task automatic smooth_pixel(input logic [PIXEL_BITS-1:0] pix);
    int unsigned           w;
    int unsigned           h;
    int unsigned           r;
    int unsigned           c;
    logic                  last_col;
    logic                  final_row;
    logic [PIXEL_BITS+1:0] sum;
    logic [PIXEL_BITS-1:0] mid;
    w = clamp_dim(int'(row_length), MAX_ROW_LENGTH);
    h = clamp_dim(int'(row_count), MAX_ROWS);
    r = int'(row_pos);
    c = int'(col_pos);
    last_col  = (c >= w - 1);
    final_row = (r >= h - 1);

    // output row r-1 comes out while row r goes in
    if (r >= 1) begin
      mid = centre_row[c];
      if (r >= 2 && r + 1 <= h && c >= 1 && !last_col) begin
        sum = {2'b00, upper_row[c]} + {2'b00, pix} + {2'b00, upper_row[c-1]}
            + {2'b00, centre_row[c+1]};
        mid = sum[PIXEL_BITS+1:2];
      end
      expected_pixels.push_back('{pixel: mid, run_end: !final_row, frame_end: 1'b0});
    end

    upper_row[c]  = centre_row[c];
    centre_row[c] = pix;

    // final row passes straight through as a second result
    if (final_row) begin
      expected_pixels.push_back('{pixel: pix, run_end: 1'b1, frame_end: last_col});
    end

    if (last_col) begin
      col_pos = '0;
      row_pos = final_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_result();
    smoothed_t want;
    seen++;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result: pixel_out %0d end_of_run %0b end_of_frame %0b",
             out_pixel_out, out_end_of_run, out_end_of_frame);
      errors++;
    end else begin
      want = expected_pixels.pop_front();
      if (out_pixel_out !== want.pixel) begin
        $error("pixel_out: expected %0d, actual %0d", want.pixel, out_pixel_out);
        errors++;
      end
      if (out_end_of_run !== want.run_end) begin
        $error("end_of_run: expected %0b, actual %0b", want.run_end, out_end_of_run);
        errors++;
      end
      if (out_end_of_frame !== want.frame_end) begin
        $error("end_of_frame: expected %0b, actual %0b", want.frame_end, out_end_of_frame);
        errors++;
      end
    end
  endtask

  // channel monitor; results are checked before the same edge's pixel is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_pixels.delete();
      row_pos    = '0;
      col_pos    = '0;
      row_length = ROW_LENGTH_BITS'(DEF_ROW_LENGTH);
      row_count  = ROW_COUNT_BITS'(DEF_ROW_COUNT);
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_LENGTH: row_length = cfg_data[ROW_LENGTH_BITS-1:0];
          CFG_ROW_COUNT:  row_count  = cfg_data[ROW_COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) smooth_pixel(in_pixel_in);
    end
    fail_count   <= errors;
    pending      <= expected_pixels.size();
    frame_rest   <= rest_of_frame();
    results_seen <= seen;
  end

endmodule

// ===== sim/tb_four_neighbour_average_smoother_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_neighbour_average_smoother_unit
// Drives pixel frames and register writes into the smoother under random
// stalls on both sides; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_four_neighbour_average_smoother_unit;
  import fnas_pkg::*;

  localparam int PIXEL_BITS    = DEF_PIXEL_BITS;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_TAIL    = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PIXELS = 560;
  localparam int WIDE_COLS     = 44;
  localparam int TALL_PIXELS   = 30;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;
  localparam logic [PIXEL_BITS-1:0] ALT_A   = 31'h5555_5555;
  localparam logic [PIXEL_BITS-1:0] ALT_B   = 31'h2AAA_AAAA;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [PIXEL_BITS-1:0]     in_pixel_in;
  logic                      out_valid;
  logic                      out_stall;
  logic [PIXEL_BITS-1:0]     out_pixel_out;
  logic                      out_end_of_run;
  logic                      out_end_of_frame;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        fail_count;
  int                        pending;
  int                        frame_rest;
  int                        results_seen;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;
  int pixels_sent = 0;
  int reg_writes  = 0;
  int quiet_cycles = 0;

  four_neighbour_average_smoother_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  fnas_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .frame_rest       (frame_rest),
    .results_seen     (results_seen)
  );

  // clock
  always #4 clk = ~clk;

  // result side: random stall bursts, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n === 1'b1 && ((in_valid && !in_stall) || (out_valid && !out_stall)
          || (cfg_valid && cfg_ready))) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("stalled for %0d cycles with %0d results outstanding", quiet_cycles, pending);
    $display("FAIL");
    $finish;
  end

  // one pixel transfer; valid stays high afterwards
  task automatic drive_pixel(input logic [PIXEL_BITS-1:0] pix);
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // let every predicted result come out, then the block's latency
  task automatic wait_for_drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // one register transfer; valid stays high afterwards
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_geometry(input bit do_len, input logic [CFG_DATA_BITS-1:0] len,
                              input bit do_cnt, input logic [CFG_DATA_BITS-1:0] cnt);
    if (do_len) write_reg(CFG_ROW_LENGTH, len);
    if (do_cnt) write_reg(CFG_ROW_COUNT, cnt);
    cfg_valid <= 1'b0;
  endtask

  // random pixels with sender gaps and the odd pause until the output drains
  task automatic send_pixels(input int count);
    logic [PIXEL_BITS-1:0] pix;
    for (int i = 0; i < count; i++) begin
      if (tx_idle_en && $urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else if (tx_idle_en && $urandom_range(0, 149) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0:       pix = '0;
        1:       pix = PIX_MAX;
        2:       pix = PIXEL_BITS'($urandom_range(0, 255));
        3:       pix = PIX_MAX - PIXEL_BITS'($urandom_range(0, 255));
        default: pix = PIXEL_BITS'($urandom());
      endcase
      drive_pixel(pix);
    end
    in_valid <= 1'b0;
  endtask

  // finish the current frame under the present settings
  task automatic send_frame_rest();
    int n;
    @(negedge clk);
    n = frame_rest;
    @(posedge clk);
    send_pixels(n);
  endtask

  initial begin
    int n;
    int random_pixels;
    logic [CFG_DATA_BITS-1:0] len_val;
    logic [CFG_DATA_BITS-1:0] cnt_val;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_ROW_LENGTH;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // clamped wide row cut short, then closed at fewer columns, so every
    // column the later frames reach holds two written rows from here on
    set_geometry(1'b1, 13'h0FFF, 1'b1, 13'd3);
    send_pixels(WIDE_COLS);
    wait_for_drain();
    set_geometry(1'b1, 13'(WIDE_COLS), 1'b0, 13'd3);
    send_frame_rest();
    wait_for_drain();

    // clamped 3x3 frame of full-scale pixels around a zero centre
    set_geometry(1'b1, 13'd2, 1'b1, 13'd0);
    for (int i = 0; i < 9; i++) drive_pixel((i == 4) ? '0 : PIX_MAX);
    in_valid <= 1'b0;
    wait_for_drain();

    // 4x3 frame of alternating bit patterns; unused length bit set
    set_geometry(1'b1, 13'h1004, 1'b1, 13'd3);
    for (int i = 0; i < 12; i++) begin
      case (i % 4)
        0:       drive_pixel(ALT_A);
        1:       drive_pixel(ALT_B);
        2:       drive_pixel(PIX_MAX);
        default: drive_pixel('0);
      endcase
    end
    in_valid <= 1'b0;
    wait_for_drain();

    // output held off while pixels keep coming, then a full drain mid-frame
    set_geometry(1'b1, 13'd7, 1'b1, 13'd9);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    send_pixels(40);
    wait_for_drain();
    tx_idle_en = 1'b1;
    send_frame_rest();
    wait_for_drain();

    // tall frame at three columns with a clamped row count, cut short and
    // closed by a small row count so the row above passes through
    set_geometry(1'b1, 13'h1003, 1'b1, 13'h1FFF);
    send_pixels(TALL_PIXELS);
    wait_for_drain();
    set_geometry(1'b0, 13'd3, 1'b1, 13'd3);
    send_frame_rest();
    wait_for_drain();

    // random frames, some cut short and resized mid-frame
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      wait_for_drain();
      case ($urandom_range(0, 9))
        0:       len_val = 13'($urandom_range(0, 2));
        1, 2:    len_val = 13'($urandom_range(11, 40));
        default: len_val = 13'($urandom_range(3, 10));
      endcase
      len_val[12] = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       cnt_val = 13'($urandom_range(0, 2));
        1:       cnt_val = 13'($urandom_range(9, 16));
        default: cnt_val = 13'($urandom_range(3, 8));
      endcase
      case ($urandom_range(0, 4))
        0:       set_geometry(1'b1, len_val, 1'b0, cnt_val);
        1:       set_geometry(1'b0, len_val, 1'b1, cnt_val);
        2:       ;
        default: set_geometry(1'b1, len_val, 1'b1, cnt_val);
      endcase
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      @(negedge clk);
      n = frame_rest;
      if (n > 1 && $urandom_range(0, 3) == 0) n = $urandom_range(1, n - 1);
      if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
      @(posedge clk);
      send_pixels(n);
      random_pixels += n;
    end
    wait_for_drain();

    // closing frames at full rate with no idling
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_geometry(1'b1, 13'd5, 1'b1, 13'd4);
    send_frame_rest();
    send_frame_rest();
    wait_for_drain();
    repeat (4 * DRAIN_TAIL) @(posedge clk);

    $display("covered %0d pixels in, %0d results out, %0d register writes", pixels_sent,
             results_seen, reg_writes);
    $display("frames from clamped 3x3 to clamped wide and tall sizes, cut short and resized");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
